/* src/cle_pkg.sv */
`timescale 1ns / 1ps

package cle_pkg;

  localparam int unsigned FIFO_DEPTH_DEF  = 256;
  localparam int unsigned LINE_LENGTH_DEF = 128;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COOKED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'd1;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    SEL_KEY  = 3'd0,
    SEL_CR   = 3'd1,
    SEL_LF   = 3'd2,
    SEL_BS   = 3'd3,
    SEL_SP   = 3'd4,
    SEL_FIFO = 3'd5,
    SEL_ZERO = 3'd6
  } char_sel_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_char;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      line_append;
    logic      line_drop;
    logic      commit_start;
    logic      commit_step;
    logic      commit_end;
    logic      fifo_push_key;
    logic      fifo_pop;
    logic      flush;
    logic      emit;
    char_sel_e char_sel;
    kind_e     kind;
    logic      last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       key_is_nl;
    logic       key_is_bs;
    logic       cooked;
    logic       echo;
    logic       line_empty;
    logic       line_room;
    logic       fifo_empty;
    logic       commit_done;
  } dp_stat_t;

endpackage

/* src/canonical_line_editor_fifo.sv */
`timescale 1ns / 1ps

// Terminal input line editor with a read FIFO. Pulse start_i with an item while
// busy_o is low; results leave on res_o for one cycle each, marked by
// res_valid_o, with res_o.last on the final one, and cannot be held off. On a
// CR/LF commit the held line is walked out of the line store one byte a cycle
// through its single read port into the FIFO. Write configuration only while
// busy_o is low and no result is pending.
module canonical_line_editor_fifo #(
  parameter int unsigned FIFO_DEPTH  = cle_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  cle_pkg::in_t                    in_i,
  input  logic                            cfg_we_i,
  input  logic [cle_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            res_valid_o,
  output cle_pkg::res_t                   res_o
);

  cle_pkg::dp_cmd_t  dp_cmd;
  cle_pkg::dp_stat_t dp_stat;

  cle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  cle_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .LINE_LENGTH(LINE_LENGTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

/* src/cle_ctrl.sv */
`timescale 1ns / 1ps

module cle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  cle_pkg::dp_stat_t  stat_i,
  output cle_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BS_SP,
    ST_BS_BS,
    ST_ECHO_LF,
    ST_COMMIT,
    ST_READ_OUT
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.char_sel = cle_pkg::SEL_ZERO;
    cmd_o.kind     = cle_pkg::KIND_ECHO;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        case (stat_i.cmd)
          cle_pkg::CMD_KEY: begin
            if (!stat_i.cooked) begin
              cmd_o.fifo_push_key = 1'b1;
            end else if (stat_i.key_is_nl) begin
              cmd_o.commit_start = 1'b1;
              if (stat_i.echo) begin
                cmd_o.emit     = 1'b1;
                cmd_o.char_sel = cle_pkg::SEL_CR;
                state_d        = ST_ECHO_LF;
              end else begin
                state_d = ST_COMMIT;
              end
            end else if (stat_i.key_is_bs) begin
              if (!stat_i.line_empty) begin
                cmd_o.line_drop = 1'b1;
                if (stat_i.echo) begin
                  cmd_o.emit     = 1'b1;
                  cmd_o.char_sel = cle_pkg::SEL_BS;
                  state_d        = ST_BS_SP;
                end
              end
            end else if (stat_i.line_room) begin
              cmd_o.line_append = 1'b1;
              if (stat_i.echo) begin
                cmd_o.emit     = 1'b1;
                cmd_o.char_sel = cle_pkg::SEL_KEY;
                cmd_o.last     = 1'b1;
              end
            end
          end
          cle_pkg::CMD_READ: begin
            if (stat_i.fifo_empty) begin
              cmd_o.emit     = 1'b1;
              cmd_o.kind     = cle_pkg::KIND_EMPTY;
              cmd_o.char_sel = cle_pkg::SEL_ZERO;
              cmd_o.last     = 1'b1;
            end else begin
              cmd_o.fifo_pop = 1'b1;
              state_d        = ST_READ_OUT;
            end
          end
          cle_pkg::CMD_FLUSH: begin
            cmd_o.flush = 1'b1;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_BS_SP: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = cle_pkg::SEL_SP;
        state_d        = ST_BS_BS;
      end
      ST_BS_BS: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = cle_pkg::SEL_BS;
        cmd_o.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_ECHO_LF: begin
        cmd_o.emit     = 1'b1;
        cmd_o.char_sel = cle_pkg::SEL_LF;
        cmd_o.last     = 1'b1;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.commit_done) begin
          cmd_o.commit_end = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.commit_step = 1'b1;
        end
      end
      ST_READ_OUT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.kind     = cle_pkg::KIND_DATA;
        cmd_o.char_sel = cle_pkg::SEL_FIFO;
        cmd_o.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/cle_dp.sv */
`timescale 1ns / 1ps

module cle_dp #(
  parameter int unsigned FIFO_DEPTH  = cle_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cle_pkg::in_t                    in_i,
  input  logic                            cfg_we_i,
  input  logic [cle_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  cle_pkg::dp_cmd_t                cmd_i,
  output cle_pkg::dp_stat_t               stat_o,
  output logic                            res_valid_o,
  output cle_pkg::res_t                   res_o
);

  localparam int unsigned FAW = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LAW = $clog2(LINE_LENGTH);

  logic cooked_q, echo_q;
  cle_pkg::in_t item_q;

  logic [7:0]     line_mem [LINE_LENGTH];
  logic [7:0]     line_rdata_q;
  logic [LAW-1:0] line_len_q, line_len_d;
  logic [LAW-1:0] idx_q, idx_d;
  logic           pend_q, pend_d;
  logic           line_rd;

  logic [7:0]     fifo_mem [FIFO_DEPTH];
  logic [7:0]     fifo_rdata_q;
  logic [FAW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FCW-1:0] count_q, count_d;
  logic           push_req, do_push;
  logic [7:0]     push_data;

  logic           res_valid_d;
  cle_pkg::res_t  res_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooked_q <= 1'b1;
      echo_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cle_pkg::REG_COOKED_MODE: cooked_q <= cfg_data_i[0];
        cle_pkg::REG_ECHO_ENABLE: echo_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
    end
  end

  always_comb begin
    stat_o.cmd         = item_q.cmd;
    stat_o.key_is_nl   = (item_q.key_char == cle_pkg::CH_LF) ||
                         (item_q.key_char == cle_pkg::CH_CR);
    stat_o.key_is_bs   = (item_q.key_char == cle_pkg::CH_BS);
    stat_o.cooked      = cooked_q;
    stat_o.echo        = echo_q;
    stat_o.line_empty  = (line_len_q == '0);
    stat_o.line_room   = (line_len_q < LAW'(LINE_LENGTH - 1));
    stat_o.fifo_empty  = (count_q == '0);
    stat_o.commit_done = (idx_q == line_len_q) && !pend_q;
  end

  // line store and commit walk: one read issued and one byte pushed per cycle
  assign line_rd = cmd_i.commit_step && (idx_q != line_len_q);

  always_comb begin
    line_len_d = line_len_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    if (cmd_i.flush || cmd_i.commit_end) begin
      line_len_d = '0;
    end else if (cmd_i.line_append) begin
      line_len_d = line_len_q + 1'b1;
    end else if (cmd_i.line_drop) begin
      line_len_d = line_len_q - 1'b1;
    end
    if (cmd_i.commit_start) begin
      idx_d  = '0;
      pend_d = 1'b0;
    end else if (cmd_i.commit_step) begin
      pend_d = line_rd;
      if (line_rd) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      line_len_q <= line_len_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.line_append) begin
      line_mem[line_len_q] <= item_q.key_char;
    end
    if (line_rd) begin
      line_rdata_q <= line_mem[idx_q];
    end
  end

  // FIFO write source
  always_comb begin
    push_req  = 1'b0;
    push_data = line_rdata_q;
    if (cmd_i.fifo_push_key) begin
      push_req  = 1'b1;
      push_data = item_q.key_char;
    end else if (cmd_i.commit_end) begin
      push_req  = 1'b1;
      push_data = cle_pkg::CH_LF;
    end else if (cmd_i.commit_step && pend_q) begin
      push_req  = 1'b1;
    end
  end

  // drop the byte when full
  assign do_push = push_req && (count_q != FCW'(FIFO_DEPTH));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (do_push) begin
      tail_d  = (tail_q == FAW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (cmd_i.fifo_pop) begin
      head_d  = (head_q == FAW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_mem[tail_q] <= push_data;
    end
    if (cmd_i.fifo_pop) begin
      fifo_rdata_q <= fifo_mem[head_q];
    end
  end

  // result register
  always_comb begin
    res_valid_d = cmd_i.emit;
    res_d.kind  = cmd_i.kind;
    res_d.last  = cmd_i.last;
    case (cmd_i.char_sel)
      cle_pkg::SEL_KEY:  res_d.out_char = item_q.key_char;
      cle_pkg::SEL_CR:   res_d.out_char = cle_pkg::CH_CR;
      cle_pkg::SEL_LF:   res_d.out_char = cle_pkg::CH_LF;
      cle_pkg::SEL_BS:   res_d.out_char = cle_pkg::CH_BS;
      cle_pkg::SEL_SP:   res_d.out_char = cle_pkg::CH_SP;
      cle_pkg::SEL_FIFO: res_d.out_char = fifo_rdata_q;
      default:           res_d.out_char = 8'h00;
    endcase
  end

  cle_pkg::res_t res_q;
  logic          res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* src/cle_chk.sv */
`timescale 1ns / 1ps

module cle_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            res_valid_o,
  input cle_pkg::res_t                   res_o
);

  // an accepted beat always occupies the block for at least the decode cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not raise busy");

  // the final result of one item is never directly followed by another result
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result right after a final result");

  // a non-final result means more results of the same item are still coming
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o)
    else $error("non-final result while idle");

  // an empty report is a lone, zero-valued result
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == cle_pkg::KIND_EMPTY) |->
      (res_o.out_char == 8'h00) && res_o.last)
    else $error("empty report with data or not final");

endmodule

bind canonical_line_editor_fifo cle_chk u_cle_chk (.*);
